[hw/rtl/pidc_pkg.sv]
// types, constants and clamp helper shared by the pid controller step block
package pidc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned ACC_W      = 36;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ACTING = 3'd6;

	localparam logic [15:0]        ELAPSED_MAX    = 16'hFFFF;
	localparam logic signed [15:0] OUT_MIN_RST    = 16'sd0;
	localparam logic signed [15:0] OUT_MAX_RST    = 16'sd255;
	localparam logic [15:0]        PERIOD_RST     = 16'd100;
	localparam logic [24:0]        ROUND_HALF     = 25'd128;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_AUTO   = 2'd2,
		KIND_MANUAL = 2'd3
	} kind_t;

	typedef struct packed {
		logic [15:0]        prop_gain;
		logic [15:0]        integral_gain;
		logic [15:0]        deriv_gain;
		logic signed [15:0] out_min;
		logic signed [15:0] out_max;
		logic [15:0]        sample_period;
		logic               reverse_acting;
	} cfg_t;

	typedef struct packed {
		logic signed [23:0] integral;
		logic signed [15:0] last_measured;
		logic [15:0]        elapsed;
		logic               auto_mode;
		logic signed [15:0] last_drive;
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] measured;
		logic signed [15:0] setpoint;
		logic signed [15:0] manual_output;
	} req_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               computed;
	} rsp_t;

	// with inverted limits, values above the upper limit take it and all others take the lower limit
	function automatic logic signed [ACC_W-1:0] clamp_lim(
		input logic signed [ACC_W-1:0] v,
		input logic signed [ACC_W-1:0] lo,
		input logic signed [ACC_W-1:0] hi
	);
		logic signed [ACC_W-1:0] r;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[hw/rtl/pidc_req_if.sv]
// request channel interface
interface pidc_req_if;
	logic             valid;
	logic             ready;
	pidc_pkg::req_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/pidc_rsp_if.sv]
// result channel interface
interface pidc_rsp_if;
	logic             valid;
	logic             ready;
	pidc_pkg::rsp_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/pidc_step.sv]
// next-state and result logic for one request
module pidc_step (
	input  pidc_pkg::cfg_t   cfg,
	input  pidc_pkg::state_t st,
	input  pidc_pkg::req_t   req,
	output pidc_pkg::state_t st_next,
	output pidc_pkg::rsp_t   rsp
);

	logic signed [16:0] err;
	logic signed [16:0] dmeas;
	logic signed [16:0] kp_s;
	logic signed [16:0] ki_s;
	logic signed [16:0] kd_s;
	logic signed [33:0] p_prod;
	logic signed [33:0] i_prod;
	logic signed [33:0] d_prod;
	logic signed [pidc_pkg::ACC_W-1:0] lo_w;
	logic signed [pidc_pkg::ACC_W-1:0] hi_w;
	logic signed [pidc_pkg::ACC_W-1:0] integ_sum;
	logic signed [pidc_pkg::ACC_W-1:0] integ_clamped;
	logic signed [pidc_pkg::ACC_W-1:0] out_sum;
	logic signed [pidc_pkg::ACC_W-1:0] out_clamped;
	logic signed [pidc_pkg::ACC_W-1:0] man_w;
	logic signed [pidc_pkg::ACC_W-1:0] man_clamped;
	logic [24:0] rounded;
	logic        due;

	assign err   = {req.setpoint[15], req.setpoint} - {req.measured[15], req.measured};
	assign dmeas = {req.measured[15], req.measured} - {st.last_measured[15], st.last_measured};

	assign kp_s = cfg.reverse_acting ? -$signed({1'b0, cfg.prop_gain})
	                                 : $signed({1'b0, cfg.prop_gain});
	assign ki_s = cfg.reverse_acting ? -$signed({1'b0, cfg.integral_gain})
	                                 : $signed({1'b0, cfg.integral_gain});
	assign kd_s = cfg.reverse_acting ? -$signed({1'b0, cfg.deriv_gain})
	                                 : $signed({1'b0, cfg.deriv_gain});

	assign p_prod = kp_s * err;
	assign i_prod = ki_s * err;
	assign d_prod = kd_s * dmeas;

	// limits scaled to q.8
	assign lo_w = {{12{cfg.out_min[15]}}, cfg.out_min, 8'h00};
	assign hi_w = {{12{cfg.out_max[15]}}, cfg.out_max, 8'h00};

	assign integ_sum     = {{12{st.integral[23]}}, st.integral} + {{2{i_prod[33]}}, i_prod};
	assign integ_clamped = pidc_pkg::clamp_lim(integ_sum, lo_w, hi_w);

	assign out_sum = {{2{p_prod[33]}}, p_prod} + integ_clamped - {{2{d_prod[33]}}, d_prod};
	assign out_clamped = pidc_pkg::clamp_lim(out_sum, lo_w, hi_w);

	// round half up, then floor
	assign rounded = out_clamped[24:0] + pidc_pkg::ROUND_HALF;

	assign man_w       = {{12{req.manual_output[15]}}, req.manual_output, 8'h00};
	assign man_clamped = pidc_pkg::clamp_lim(man_w, lo_w, hi_w);

	assign due = st.auto_mode && (st.elapsed >= cfg.sample_period);

	always_comb begin
		st_next      = st;
		rsp.computed = 1'b0;
		unique case (req.kind)
			pidc_pkg::KIND_TICK: begin
				if (st.elapsed != pidc_pkg::ELAPSED_MAX) begin
					st_next.elapsed = st.elapsed + 16'd1;
				end
			end
			pidc_pkg::KIND_AUTO: begin
				if (!st.auto_mode) begin
					st_next.integral      = man_clamped[23:0];
					st_next.last_measured = req.measured;
					st_next.auto_mode     = 1'b1;
				end
			end
			pidc_pkg::KIND_MANUAL: begin
				st_next.auto_mode = 1'b0;
			end
			pidc_pkg::KIND_SAMPLE: begin
				if (due) begin
					st_next.integral      = integ_clamped[23:0];
					st_next.last_measured = req.measured;
					st_next.elapsed       = 16'd0;
					st_next.last_drive    = rounded[23:8];
					rsp.computed          = 1'b1;
				end
			end
			default: begin
				st_next = st;
			end
		endcase
		rsp.drive = st_next.last_drive;
	end

endmodule

[hw/rtl/pid_controller_step.sv]
// top level of the pid controller step block
//
// channel  modport  carries
// cmd      sink     kind, measured, setpoint, manual_output
// res      source   drive, computed
// cfg_*    write    cfg_we, cfg_idx, cfg_data
//
// a request is registered, then the step logic (three 17x17 multipliers,
// two adds and three clamps) is combinational into the result register
// one request per cycle sustained while res is ready; a request passes req_s1, then rsp_s2
// arst_n clears mode, gains and controller state but sets elapsed to its maximum, limits and period take defaults
// a result not taken holds the step register, which then holds cmd
module pid_controller_step (
	input  logic                             clk,
	input  logic                             arst_n,
	pidc_req_if.sink                         cmd,
	pidc_rsp_if.source                       res,
	input  logic                             cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pidc_pkg::cfg_t   cfg_q;
	pidc_pkg::state_t st_q;
	pidc_pkg::state_t st_next;
	pidc_pkg::req_t   req_s1;
	pidc_pkg::rsp_t   rsp_next;
	pidc_pkg::rsp_t   rsp_s2;
	logic             vld_s1;
	logic             vld_s2;
	logic             advance;

	assign advance   = vld_s1 && (!vld_s2 || res.ready);
	assign cmd.ready = !vld_s1 || advance;

	assign res.valid   = vld_s2;
	assign res.payload = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= '0;
			cfg_q.integral_gain  <= '0;
			cfg_q.deriv_gain     <= '0;
			cfg_q.out_min        <= pidc_pkg::OUT_MIN_RST;
			cfg_q.out_max        <= pidc_pkg::OUT_MAX_RST;
			cfg_q.sample_period  <= pidc_pkg::PERIOD_RST;
			cfg_q.reverse_acting <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pidc_pkg::CFG_PROP_GAIN:      cfg_q.prop_gain      <= cfg_data;
				pidc_pkg::CFG_INTEGRAL_GAIN:  cfg_q.integral_gain  <= cfg_data;
				pidc_pkg::CFG_DERIV_GAIN:     cfg_q.deriv_gain     <= cfg_data;
				pidc_pkg::CFG_OUT_MIN:        cfg_q.out_min        <= $signed(cfg_data);
				pidc_pkg::CFG_OUT_MAX:        cfg_q.out_max        <= $signed(cfg_data);
				pidc_pkg::CFG_SAMPLE_PERIOD:  cfg_q.sample_period  <= cfg_data;
				pidc_pkg::CFG_REVERSE_ACTING: cfg_q.reverse_acting <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			req_s1 <= cmd.payload;
		end
	end

	pidc_step u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.req     (req_s1),
		.st_next (st_next),
		.rsp     (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.integral      <= '0;
			st_q.last_measured <= '0;
			st_q.elapsed       <= pidc_pkg::ELAPSED_MAX;
			st_q.auto_mode     <= 1'b0;
			st_q.last_drive    <= '0;
			vld_s2             <= 1'b0;
		end else begin
			if (advance) begin
				st_q   <= st_next;
				vld_s2 <= 1'b1;
			end else if (res.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

`ifndef SYNTHESIS
	a_drive_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (rsp_s2.drive == st_q.last_drive))
		else $error("result drive differs from held drive");

	a_computed_in_auto: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && rsp_s2.computed) |-> (st_q.auto_mode && st_q.elapsed == 16'd0))
		else $error("computation outside automatic mode or elapsed not restarted");

	a_stalled_step_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !advance) |=> (vld_s1 && $stable(req_s1) && $stable(st_q)))
		else $error("step register or state moved while stalled");
`endif

endmodule
